FILE: design/segregated_pool_allocator_assert.svh
// Assertion macros used by the allocator RTL.
`ifndef SEGREGATED_POOL_ALLOCATOR_ASSERT_SVH
`define SEGREGATED_POOL_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/spa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spa_pkg
// Shared constants, codes, types and pool geometry functions.
// ----------------------------------------------------------------------------
package spa_pkg;

    localparam int NUM_POOLS     = 7;
    localparam int MAX_POOLS     = 8;
    localparam int ADDR_W        = 48;
    localparam int SIZE_W        = 32;
    localparam int BYTES_W       = 19;
    localparam int REGION_LOG2   = 21;
    localparam int SMALLEST_LOG2 = 6;
    localparam int IDX_W         = 16;
    localparam int LINK_DEPTH    = 45640;
    localparam int LOG2_W        = 5;
    localparam int POOL_W        = 3;
    localparam int IN_TDATA_W    = 120;
    localparam int OUT_TDATA_W   = 72;

    localparam logic [IDX_W-1:0] LINK_NIL = '1;

    localparam int POOL_SHIFT [MAX_POOLS] = '{0, 3, 3, 3, 6, 9, 12, 15};

    typedef logic [POOL_W-1:0] t_pool;
    typedef logic [IDX_W-1:0]  t_idx;

    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_FREE,
        OP_QUERY,
        OP_NONE
    } t_op;

    typedef enum logic [1:0] {
        STS_OK,
        STS_ALLOC_FAIL,
        STS_BAD_FREE
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_A_POOL,
        ST_A_INIT,
        ST_A_CHECK,
        ST_A_WAIT,
        ST_O_POOL,
        ST_O_TEST,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic en;
        t_idx addr;
        t_idx data;
    } t_link_wr;

    typedef struct packed {
        logic en;
        t_idx addr;
    } t_link_rd;

    function automatic logic [LOG2_W-1:0] f_chunk_log2(input t_pool p);
        return LOG2_W'(SMALLEST_LOG2 + POOL_SHIFT[p]);
    endfunction

    function automatic t_idx f_count(input t_pool p);
        logic [LOG2_W-1:0] sh;
        sh = LOG2_W'(REGION_LOG2) - f_chunk_log2(p);
        return t_idx'(1) << sh;
    endfunction

    function automatic t_idx f_link_base(input t_pool p);
        t_idx acc;
        acc = '0;
        for (int q = 0; q < MAX_POOLS; q++) begin
            if (POOL_W'(q) < p) begin
                acc = acc + f_count(POOL_W'(q));
            end
        end
        return acc;
    endfunction

    function automatic logic [BYTES_W-1:0] f_chunk_bytes(input t_pool p);
        return BYTES_W'(1) << f_chunk_log2(p);
    endfunction

endpackage
`default_nettype wire

FILE: design/spa_rem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spa_rem
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module spa_rem (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [spa_pkg::ADDR_W-1:0]  i_dividend,
    input  wire logic [spa_pkg::SIZE_W-1:0]  i_divisor,
    output logic                             o_busy,
    output logic      [spa_pkg::SIZE_W-1:0]  o_rem
);
    import spa_pkg::*;

    localparam int CNT_W = $clog2(ADDR_W);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [ADDR_W-1:0] r_dvd;
    logic [SIZE_W-1:0] r_dvs;
    logic [SIZE_W-1:0] r_rem;
    logic [SIZE_W:0]   trial;
    logic [SIZE_W:0]   n_rem;

    // Shift in one dividend bit, subtract when it fits.
    always_comb begin
        trial = {r_rem, r_dvd[ADDR_W-1]};
        if (trial >= {1'b0, r_dvs}) begin
            n_rem = trial - {1'b0, r_dvs};
        end else begin
            n_rem = trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == CNT_W'(ADDR_W - 1)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= '0;
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            r_dvd <= r_dvd << 1;
            r_rem <= n_rem[SIZE_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

FILE: design/spa_link_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spa_link_ram
// Free-list link memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module spa_link_ram (
    input  wire logic              i_clk,
    input  wire spa_pkg::t_link_wr i_wr,
    input  wire spa_pkg::t_link_rd i_rd,
    output spa_pkg::t_idx          o_rdata
);
    import spa_pkg::*;

    t_idx r_mem [LINK_DEPTH];
    t_idx r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rdata <= r_mem[i_rd.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: design/segregated_pool_allocator.sv
// Free and query: pools are scanned in order, each ready pool's region tested in turn.
// Allocate: a free-list node examined with nonzero alignment waits on the remainder unit,
//   one without does not; first use of a pool builds its list, one link write per chunk.
// Throughput: one beat at a time; the next beat is taken once the result is in the output reg.
// Reset: synchronous active low; pools unused, region counter and region_base cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "segregated_pool_allocator_assert.svh"
// ----------------------------------------------------------------------------
// segregated_pool_allocator
// Seven fixed-chunk pools with lazily assigned regions and free lists in RAM.
// ----------------------------------------------------------------------------
module segregated_pool_allocator (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Config: region_base
    input  wire logic                              i_cfg_we,
    input  wire logic [spa_pkg::ADDR_W-1:0]        i_cfg_wdata,
    // Request beat
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata: op[1:0], req_size[33:2], req_align[65:34], chunk_addr[113:66], zero pad
    input  wire logic [spa_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // Result beat
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // tdata: status[1:0], granted_addr[49:2], chunk_bytes[68:50], zero pad
    output logic      [spa_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import spa_pkg::*;

    // Sequencer and request registers
    t_state              r_state, n_state;
    t_op                 r_op, n_op;
    logic [SIZE_W-1:0]   r_size, n_size;
    logic [SIZE_W-1:0]   r_align, n_align;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [ADDR_W-1:0]   r_base, n_base;

    // Pool bookkeeping
    logic [NUM_POOLS-1:0] r_ready, n_ready;
    t_pool               r_region [NUM_POOLS];
    t_pool               n_region [NUM_POOLS];
    t_pool               r_regions_used, n_regions_used;
    t_idx                r_head [NUM_POOLS];
    t_idx                n_head [NUM_POOLS];

    // Walk state
    t_pool               r_pool, n_pool;
    logic [ADDR_W-1:0]   r_start, n_start;
    t_idx                r_cur, n_cur;
    t_idx                r_prev, n_prev;
    logic                r_prev_nil, n_prev_nil;
    t_idx                r_steps, n_steps;
    t_idx                r_idx, n_idx;
    logic [ADDR_W-1:0]   r_cand, n_cand;

    // Result and output register
    t_status             r_res_status, n_res_status;
    logic [ADDR_W-1:0]   r_res_granted, n_res_granted;
    logic [BYTES_W-1:0]  r_res_bytes, n_res_bytes;
    logic                r_out_valid, n_out_valid;
    t_status             r_out_status;
    logic [ADDR_W-1:0]   r_out_granted;
    logic [BYTES_W-1:0]  r_out_bytes;
    logic                out_load;

    // Shared units
    t_link_wr            link_wr;
    t_link_rd            link_rd;
    t_idx                link_rdata;
    logic                rem_start;
    logic [ADDR_W-1:0]   rem_dividend;
    logic                rem_busy;
    logic [SIZE_W-1:0]   rem_val;

    // Per-pool geometry of the pool under work
    logic [LOG2_W-1:0]   cur_log2;
    t_idx                cur_count;
    t_idx                cur_lbase;
    logic [BYTES_W-1:0]  cur_bytes;
    logic [ADDR_W-1:0]   off;
    logic [ADDR_W-1:0]   off_mask;
    logic                last_pool;

    assign cur_log2  = f_chunk_log2(r_pool);
    assign cur_count = f_count(r_pool);
    assign cur_lbase = f_link_base(r_pool);
    assign cur_bytes = f_chunk_bytes(r_pool);
    assign off       = r_addr - r_start;
    assign off_mask  = (ADDR_W'(1) << cur_log2) - ADDR_W'(1);
    assign last_pool = (r_pool == POOL_W'(NUM_POOLS - 1));

    spa_link_ram u_link_ram (
        .i_clk   (i_clk),
        .i_wr    (link_wr),
        .i_rd    (link_rd),
        .o_rdata (link_rdata)
    );

    spa_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (rem_dividend),
        .i_divisor  (r_align),
        .o_busy     (rem_busy),
        .o_rem      (rem_val)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_ready        <= '0;
            r_regions_used <= '0;
            r_base         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_ready        <= n_ready;
            r_regions_used <= n_regions_used;
            r_base         <= n_base;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op          <= n_op;
        r_size        <= n_size;
        r_align       <= n_align;
        r_addr        <= n_addr;
        r_region      <= n_region;
        r_head        <= n_head;
        r_pool        <= n_pool;
        r_start       <= n_start;
        r_cur         <= n_cur;
        r_prev        <= n_prev;
        r_prev_nil    <= n_prev_nil;
        r_steps       <= n_steps;
        r_idx         <= n_idx;
        r_cand        <= n_cand;
        r_res_status  <= n_res_status;
        r_res_granted <= n_res_granted;
        r_res_bytes   <= n_res_bytes;
        if (out_load) begin
            r_out_status  <= r_res_status;
            r_out_granted <= r_res_granted;
            r_out_bytes   <= r_res_bytes;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_op           = r_op;
        n_size         = r_size;
        n_align        = r_align;
        n_addr         = r_addr;
        n_base         = i_cfg_we ? i_cfg_wdata : r_base;
        n_ready        = r_ready;
        n_region       = r_region;
        n_regions_used = r_regions_used;
        n_head         = r_head;
        n_pool         = r_pool;
        n_start        = r_start;
        n_cur          = r_cur;
        n_prev         = r_prev;
        n_prev_nil     = r_prev_nil;
        n_steps        = r_steps;
        n_idx          = r_idx;
        n_cand         = r_cand;
        n_res_status   = r_res_status;
        n_res_granted  = r_res_granted;
        n_res_bytes    = r_res_bytes;
        link_wr        = '0;
        link_rd        = '0;
        rem_start      = 1'b0;
        rem_dividend   = r_start + (ADDR_W'(r_cur) << cur_log2);
        out_load       = 1'b0;
        // Drop the result once the sink takes it
        n_out_valid    = r_out_valid && !m_axis_tready;

        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_op          = t_op'(s_axis_tdata[1:0]);
                    n_size        = s_axis_tdata[33:2];
                    n_align       = s_axis_tdata[65:34];
                    n_addr        = s_axis_tdata[113:66];
                    n_pool        = '0;
                    n_res_status  = STS_OK;
                    n_res_granted = '0;
                    n_res_bytes   = '0;
                    case (t_op'(s_axis_tdata[1:0]))
                        OP_ALLOC: n_state = ST_A_POOL;
                        OP_FREE:  n_state = ST_O_POOL;
                        OP_QUERY: n_state = ST_O_POOL;
                        default:  n_state = ST_DONE;
                    endcase
                end
            end

            ST_A_POOL: begin
                if ({{(SIZE_W - BYTES_W){1'b0}}, cur_bytes} >= r_size) begin
                    n_prev_nil = 1'b1;
                    n_steps    = '0;
                    if (!r_ready[r_pool]) begin
                        // First touch: claim the next region and build the list
                        n_ready[r_pool]  = 1'b1;
                        n_region[r_pool] = r_regions_used;
                        n_regions_used   = r_regions_used + POOL_W'(1);
                        n_start = r_base + (ADDR_W'(r_regions_used) << REGION_LOG2);
                        n_idx   = '0;
                        n_state = ST_A_INIT;
                    end else begin
                        n_start = r_base + (ADDR_W'(r_region[r_pool]) << REGION_LOG2);
                        n_cur   = r_head[r_pool];
                        n_state = ST_A_CHECK;
                    end
                end else if (last_pool) begin
                    n_res_status = STS_ALLOC_FAIL;
                    n_state      = ST_DONE;
                end else begin
                    n_pool = r_pool + POOL_W'(1);
                end
            end

            ST_A_INIT: begin
                link_wr.en   = 1'b1;
                link_wr.addr = cur_lbase + r_idx;
                if (r_idx == cur_count - t_idx'(1)) begin
                    link_wr.data   = LINK_NIL;
                    n_head[r_pool] = '0;
                    n_cur          = '0;
                    n_state        = ST_A_CHECK;
                end else begin
                    link_wr.data = r_idx + t_idx'(1);
                    n_idx        = r_idx + t_idx'(1);
                end
            end

            ST_A_CHECK: begin
                if (r_cur != LINK_NIL && r_cur < cur_count && r_steps < cur_count) begin
                    n_cand       = rem_dividend;
                    link_rd.en   = 1'b1;
                    link_rd.addr = cur_lbase + r_cur;
                    rem_start    = (r_align != '0);
                    n_state      = ST_A_WAIT;
                end else if (last_pool) begin
                    n_res_status = STS_ALLOC_FAIL;
                    n_state      = ST_DONE;
                end else begin
                    n_pool  = r_pool + POOL_W'(1);
                    n_state = ST_A_POOL;
                end
            end

            ST_A_WAIT: begin
                if (r_align == '0 || !rem_busy) begin
                    if (r_align == '0 || rem_val == '0) begin
                        // Unlink the chunk
                        if (r_prev_nil) begin
                            n_head[r_pool] = link_rdata;
                        end else begin
                            link_wr.en   = 1'b1;
                            link_wr.addr = cur_lbase + r_prev;
                            link_wr.data = link_rdata;
                        end
                        n_res_granted = r_cand;
                        n_state       = ST_DONE;
                    end else begin
                        n_prev     = r_cur;
                        n_prev_nil = 1'b0;
                        n_cur      = link_rdata;
                        n_steps    = r_steps + t_idx'(1);
                        n_state    = ST_A_CHECK;
                    end
                end
            end

            ST_O_POOL: begin
                if (r_ready[r_pool]) begin
                    n_start = r_base + (ADDR_W'(r_region[r_pool]) << REGION_LOG2);
                    n_state = ST_O_TEST;
                end else if (last_pool) begin
                    n_res_status = (r_op == OP_FREE) ? STS_BAD_FREE : STS_OK;
                    n_state      = ST_DONE;
                end else begin
                    n_pool = r_pool + POOL_W'(1);
                end
            end

            ST_O_TEST: begin
                if (off[ADDR_W-1:REGION_LOG2] == '0 && (off & off_mask) == '0) begin
                    if (r_op == OP_FREE) begin
                        // Push onto the list head
                        link_wr.en     = 1'b1;
                        link_wr.addr   = cur_lbase + t_idx'(off >> cur_log2);
                        link_wr.data   = r_head[r_pool];
                        n_head[r_pool] = t_idx'(off >> cur_log2);
                    end else begin
                        n_res_bytes = cur_bytes;
                    end
                    n_state = ST_DONE;
                end else if (last_pool) begin
                    n_res_status = (r_op == OP_FREE) ? STS_BAD_FREE : STS_OK;
                    n_state      = ST_DONE;
                end else begin
                    n_pool  = r_pool + POOL_W'(1);
                    n_state = ST_O_POOL;
                end
            end

            ST_DONE: begin
                // Hold until the output register frees up
                if (!r_out_valid || m_axis_tready) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - 2 - ADDR_W - BYTES_W){1'b0}},
                            r_out_bytes, r_out_granted, r_out_status};

    `SPA_ASSERT_NOW(a_busy_blocks_input, i_clk, i_rst_n, r_state != ST_IDLE, !s_axis_tready, "request taken while busy")
    `SPA_ASSERT_NOW(a_regions_match_ready, i_clk, i_rst_n, 1'b1, $countones(r_ready) == int'(r_regions_used), "region count out of step with ready pools")
    `SPA_ASSERT_NOW(a_rem_bounded, i_clk, i_rst_n, r_state == ST_A_WAIT && !rem_busy && r_align != '0, rem_val < r_align, "remainder not below alignment")
    `SPA_ASSERT_NOW(a_fail_no_grant, i_clk, i_rst_n, r_out_valid && r_out_status != STS_OK, r_out_granted == '0, "grant on error status")
    `SPA_ASSERT_NEXT(a_done_loads, i_clk, i_rst_n, r_state == ST_DONE && (!r_out_valid || m_axis_tready), r_state == ST_IDLE && r_out_valid, "result not loaded")

endmodule
`default_nettype wire

FILE: dv/tb_segregated_pool_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segregated_pool_allocator
// Stream-level test of the pool allocator: allocate, free, query and unused
// op beats are sent, and a local allocator model predicts every result beat.
// Region base is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_segregated_pool_allocator;
    import spa_pkg::*;

    localparam int  NPOOL      = 7;
    localparam int  REGION_LG  = 21;
    localparam int  WDOG_LIMIT = 200000;
    localparam int  DRAIN_CYC  = 40;
    localparam int unsigned NO_LINK = 32'hFFFF_FFFF;
    localparam int  CHUNK_LG [NPOOL] = '{6, 9, 9, 9, 12, 15, 18};

    typedef struct {
        logic [1:0]  status;
        logic [47:0] granted;
        logic [18:0] bytes;
    } t_result;

    typedef struct {
        int p;
        int unsigned idx;
    } t_chunk_ref;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [ADDR_W-1:0]       i_cfg_wdata;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    // op[1:0], req_size[33:2], req_align[65:34], chunk_addr[113:66], zero pad
    logic [IN_TDATA_W-1:0]   s_axis_tdata;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    // status[1:0], granted_addr[49:2], chunk_bytes[68:50], zero pad
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;

    segregated_pool_allocator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Allocator model state
    logic [47:0]  pool_base_reg;
    bit           pool_live [NPOOL];
    int unsigned  pool_slot [NPOOL];
    int unsigned  slots_taken;
    int unsigned  list_head [NPOOL];
    int unsigned  list_off  [NPOOL];
    int unsigned  list_next [LINK_DEPTH];

    t_result      pending_results[$];
    t_chunk_ref   held_chunks[$];

    bit  gaps_on;
    int  errors;
    int  mismatches;
    int  idle_cycles;
    int  n_alloc_ok, n_alloc_fail, n_free_ok, n_free_bad, n_query, n_nop;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic longint unsigned chunk_size(int p);
        return 64'd1 << CHUNK_LG[p];
    endfunction

    function automatic int unsigned chunk_total(int p);
        return 1 << (REGION_LG - CHUNK_LG[p]);
    endfunction

    function automatic logic [47:0] region_addr(int p);
        return 48'(pool_base_reg + 48'(pool_slot[p]) * 48'(1 << REGION_LG));
    endfunction

    function automatic logic [47:0] chunk_addr_of(int p, int unsigned i);
        return 48'(region_addr(p) + 48'(64'(i) * chunk_size(p)));
    endfunction

    function automatic void model_reset();
        int unsigned acc;
        acc = 0;
        pool_base_reg = '0;
        slots_taken   = 0;
        for (int p = 0; p < NPOOL; p++) begin
            pool_live[p] = 1'b0;
            pool_slot[p] = 0;
            list_head[p] = 0;
            list_off[p]  = acc;
            acc += chunk_total(p);
        end
    endfunction

    // Carve a region for a pool on its first allocation attempt.
    function automatic void build_pool(int p);
        int unsigned n;
        n = chunk_total(p);
        pool_live[p] = 1'b1;
        pool_slot[p] = slots_taken;
        slots_taken++;
        for (int unsigned i = 0; i < n; i++)
            list_next[list_off[p] + i] = (i + 1 < n) ? i + 1 : NO_LINK;
        list_head[p] = 0;
    endfunction

    // Walk the free list (bounded by chunk count) for the first aligned chunk.
    function automatic bit grab_chunk(int p, logic [31:0] align, output int unsigned got);
        int unsigned n, cur, prev, nxt, steps;
        logic [47:0] a;
        got = 0;
        if (!pool_live[p]) build_pool(p);
        n = chunk_total(p);
        cur = list_head[p];
        prev = NO_LINK;
        steps = 0;
        while (cur != NO_LINK && cur < n && steps < n) begin
            a = chunk_addr_of(p, cur);
            nxt = list_next[list_off[p] + cur];
            if (align == 0 || (64'(a) % 64'(align)) == 0) begin
                if (prev == NO_LINK) list_head[p] = nxt;
                else list_next[list_off[p] + prev] = nxt;
                got = cur;
                return 1'b1;
            end
            prev = cur;
            cur = nxt;
            steps++;
        end
        return 1'b0;
    endfunction

    function automatic int owning_pool(logic [47:0] addr, output int unsigned i);
        logic [47:0] off;
        i = 0;
        for (int p = 0; p < NPOOL; p++) begin
            if (pool_live[p]) begin
                off = 48'(addr - region_addr(p));
                if (64'(off) < 64'(chunk_total(p)) * chunk_size(p) &&
                    64'(off) % chunk_size(p) == 0) begin
                    i = int'(64'(off) / chunk_size(p));
                    return p;
                end
            end
        end
        return NPOOL;
    endfunction

    // Apply one request to the model and return the expected result beat.
    function automatic t_result apply_request(t_op op, logic [31:0] size, logic [31:0] align,
                                              logic [47:0] addr);
        t_result r;
        int p;
        int unsigned i;
        bit ok;
        r.status = STS_OK;
        r.granted = '0;
        r.bytes = '0;
        ok = 1'b0;
        case (op)
            OP_ALLOC: begin
                for (p = 0; p < NPOOL && !ok; p++) begin
                    if (64'(size) <= chunk_size(p)) begin
                        ok = grab_chunk(p, align, i);
                        if (ok) begin
                            r.granted = chunk_addr_of(p, i);
                            held_chunks.push_back('{p, i});
                        end
                    end
                end
                if (!ok) r.status = STS_ALLOC_FAIL;
                if (ok) n_alloc_ok++; else n_alloc_fail++;
            end
            OP_FREE: begin
                p = owning_pool(addr, i);
                if (p >= NPOOL) begin
                    r.status = STS_BAD_FREE;
                    n_free_bad++;
                end else begin
                    list_next[list_off[p] + i] = list_head[p];
                    list_head[p] = i;
                    n_free_ok++;
                end
            end
            OP_QUERY: begin
                p = owning_pool(addr, i);
                if (p < NPOOL) r.bytes = 19'(chunk_size(p));
                n_query++;
            end
            default: n_nop++;
        endcase
        return r;
    endfunction

    // Drive one request beat, record its prediction on acceptance.
    task automatic send_request(t_op op, logic [31:0] size, logic [31:0] align,
                                logic [47:0] addr);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, addr, align, size, op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_results.push_back(apply_request(op, size, align, addr));
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12) - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYC) @(negedge i_clk);
    endtask

    task automatic write_region_base(logic [47:0] v);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        pool_base_reg = v;
    endtask

    // Pick a chunk address: a held chunk (removed when freeing) or any chunk of a random pool, live or not.
    function automatic logic [47:0] pick_live_addr(bit take);
        int k, p;
        t_chunk_ref c;
        if (held_chunks.size() != 0 && (take || $urandom_range(0, 1))) begin
            k = $urandom_range(0, held_chunks.size() - 1);
            c = held_chunks[k];
            if (take) held_chunks.delete(k);
            return chunk_addr_of(c.p, c.idx);
        end
        p = $urandom_range(0, NPOOL - 1);
        return chunk_addr_of(p, $urandom_range(0, chunk_total(p) - 1));
    endfunction

    function automatic logic [47:0] foreign_addr();
        logic [47:0] a;
        a = {$urandom(), $urandom()};
        if (48'(a - pool_base_reg) % 48'd64 == 0) a ^= 48'd1;
        return a;
    endfunction

    // One random request. any_align allows aligned allocations (base must be aligned).
    task automatic random_request(bit any_align);
        int sel, tgt, lo;
        logic [31:0] size, align;
        logic [47:0] addr;
        sel = $urandom_range(0, 99);
        size = '0;
        align = '0;
        addr = {$urandom(), $urandom()};
        if (sel < 45) begin
            tgt = $urandom_range(0, 99);
            tgt = (tgt < 35) ? 0 : (tgt < 65) ? 1 : (tgt < 80) ? 4 :
                  (tgt < 90) ? 5 : (tgt < 95) ? 6 : NPOOL;
            if (tgt == NPOOL) begin
                size = $urandom_range(262145, 32'hFFFF_FFFF);
                align = $urandom();
            end else begin
                lo = (tgt == 0) ? 0 : int'(chunk_size(tgt == 4 ? 1 : tgt - 1)) + 1;
                size = $urandom_range(lo, int'(chunk_size(tgt)));
                if (any_align && $urandom_range(0, 1)) begin
                    if (tgt == 6) align = $urandom();
                    else if ($urandom_range(0, 3) == 0) align = $urandom_range(1, 7);
                    else align = 32'd1 << $urandom_range(0, CHUNK_LG[tgt]);
                end
            end
            send_request(OP_ALLOC, size, align, addr);
        end else if (sel < 75) begin
            addr = ($urandom_range(0, 4) != 0 && held_chunks.size() != 0) ?
                   pick_live_addr(1'b1) : foreign_addr();
            send_request(OP_FREE, $urandom(), $urandom(), addr);
        end else if (sel < 95) begin
            if (sel < 88) addr = pick_live_addr(1'b0);
            else if (sel < 91) addr = foreign_addr();
            else if (pool_live[0]) addr = 48'(region_addr(0) + 48'(1 << REGION_LG));
            send_request(OP_QUERY, $urandom(), $urandom(), addr);
        end else begin
            send_request(OP_NONE, $urandom(), $urandom(), addr);
        end
    endtask

    // Edges of every field, every op, and the special cases named by the spec.
    task automatic test_directed();
        logic [47:0] a6;
        send_request(OP_QUERY, '0, '0, 48'd0);                  // nothing owned yet
        send_request(OP_NONE, '1, '1, '1);                      // unused op code
        send_request(OP_ALLOC, 32'd0, 32'd0, '0);               // builds pool 0
        send_request(OP_ALLOC, 32'd64, 32'd7, '0);
        send_request(OP_ALLOC, 32'hFFFF_FFFF, 32'd0, '0);       // oversized
        send_request(OP_ALLOC, 32'd262145, 32'd1, '0);
        send_request(OP_ALLOC, 32'd65, 32'd4096, '0);
        send_request(OP_ALLOC, 32'd262144, 32'd262144, '0);
        a6 = chunk_addr_of(6, 0);
        send_request(OP_QUERY, '0, '0, a6);
        send_request(OP_QUERY, '0, '0, 48'(region_addr(0) + 48'(1 << REGION_LG) - 48'd64));
        send_request(OP_QUERY, '0, '0, '1);
        send_request(OP_FREE, '0, '0, '1);                      // foreign
        send_request(OP_FREE, '0, '0, 48'(chunk_addr_of(0, 0) + 48'd8));
        send_request(OP_FREE, '0, '0, chunk_addr_of(0, 0));
        // Corrupt pool 6 with a double free, then force a bounded walk that fails.
        send_request(OP_FREE, '0, '0, a6);
        send_request(OP_FREE, '0, '0, a6);
        send_request(OP_ALLOC, 32'd40000, 32'hFFFF_FFFF, '0);
        send_request(OP_ALLOC, 32'd40000, 32'd0, '0);
        send_request(OP_ALLOC, 32'd262144, 32'd0, '0);
        held_chunks.delete();                                   // drop duplicates
    endtask

    task automatic test_random(int n, bit any_align);
        repeat (n) random_request(any_align);
    endtask

    task automatic test_region_moves();
        write_region_base(48'({$urandom(), $urandom()}) << REGION_LG);
        test_random(400, 1'b1);
        write_region_base('1);                                  // unaligned, wraps
        test_random(250, 1'b0);
        write_region_base(48'd0);
    endtask

    // Check each result beat against the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("unexpected result beat %h", m_axis_tdata);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[1:0] !== want.status || m_axis_tdata[49:2] !== want.granted ||
                    m_axis_tdata[68:50] !== want.bytes || m_axis_tdata[71:69] !== 3'b0) begin
                    errors++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp status %0d addr %h bytes %0d, got %0d %h %0d",
                                 want.status, want.granted, want.bytes, m_axis_tdata[1:0],
                                 m_axis_tdata[49:2], m_axis_tdata[68:50]);
                end
            end
        end
    end

    // Result-side backpressure in random bursts.
    initial begin
        m_axis_tready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (gaps_on && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Stop if nothing moves on either side for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("watchdog expired, %0d results outstanding", pending_results.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        gaps_on       = 1'b1;
        errors        = 0;
        mismatches    = 0;
        idle_cycles   = 0;
        {n_alloc_ok, n_alloc_fail, n_free_ok, n_free_bad, n_query, n_nop} = '0;
        model_reset();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        write_region_base(48'd0);
        test_random(500, 1'b1);
        test_region_moves();
        gaps_on = 1'b0;
        test_random(300, 1'b1);

        wait_idle();
        if (pending_results.size() != 0) errors++;
        $display("covered %0d allocs ok, %0d failed, %0d frees, %0d bad frees",
                 n_alloc_ok, n_alloc_fail, n_free_ok, n_free_bad);
        $display("plus %0d queries, %0d unused ops, four region bases; %0d errors",
                 n_query, n_nop, errors);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+design
design/spa_pkg.sv
design/spa_rem.sv
design/spa_link_ram.sv
design/segregated_pool_allocator.sv
dv/tb_segregated_pool_allocator.sv
